// ===== hw/rtl/mmrlp_pkg.sv =====
`default_nettype none

package mmrlp_pkg;

  localparam int unsigned TEXT_BYTES_DEF = 256;
  localparam int unsigned PFX_COUNT = 6;
  localparam int unsigned PFX_MAX_LEN = 14;

  // Item kinds on the result channel.
  localparam logic [1:0] KIND_TOPIC   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_RESULT  = 2'd2;

  // Event codes.
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_CONNECT = 3'd1;
  localparam logic [2:0] EV_CONNACK = 3'd2;
  localparam logic [2:0] EV_PUBLISH = 3'd3;
  localparam logic [2:0] EV_PUBACK  = 3'd4;
  localparam logic [2:0] EV_SUBACK  = 3'd5;
  localparam logic [2:0] EV_DISC    = 3'd6;

  // Phases of the decimal field reader.
  localparam logic [1:0] NUM_SKIP   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE   = 2'd2;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Common head of all prefixes: plus sign followed by the vendor tag.
  localparam logic [47:0] PFX_HEAD = 48'h2B434D515454;

  typedef struct packed {
    logic [3:0] pos;
    logic [5:0] cand;
    logic [2:0] code;
  } pfx_st_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        neg;
    logic [31:0] acc;
  } num_st_t;

  function automatic logic [3:0] pfx_len(input logic [2:0] idx);
    logic [3:0] len;
    case (idx)
      3'd0, 3'd1, 3'd2: len = 4'd14;
      3'd3, 3'd4: len = 4'd13;
      3'd5: len = 4'd11;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pfx_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [111:0] s;
    logic [7:0] ch;
    case (idx)
      3'd0: s = {PFX_HEAD, "CONNECT:"};
      3'd1: s = {PFX_HEAD, "CONNACK:"};
      3'd2: s = {PFX_HEAD, "PUBLISH:"};
      3'd3: s = {PFX_HEAD, "PUBACK:", 8'h00};
      3'd4: s = {PFX_HEAD, "SUBACK:", 8'h00};
      3'd5: s = {PFX_HEAD, "DISC:", 24'h000000};
      default: s = '0;
    endcase
    if (pos < 4'(PFX_MAX_LEN)) begin
      ch = s[8 * (13 - int'(pos)) +: 8];
    end else begin
      ch = CH_NUL;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmrlp_if.sv =====
`default_nettype none

interface mmrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;

  modport source (output valid, output line_byte, output line_last, input ready);
  modport sink (input valid, input line_byte, input line_last, output ready);
endinterface

interface mmrlp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [7:0]         text_byte;
  logic [2:0]         event_code;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic [7:0]         topic_length;
  logic [7:0]         payload_length;

  modport source (output valid, output item_kind, output text_byte, output event_code,
                  output first_value, output second_value, output topic_length,
                  output payload_length, input ready);
  modport sink (input valid, input item_kind, input text_byte, input event_code,
                input first_value, input second_value, input topic_length,
                input payload_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/modem_mqtt_response_line_parser.sv =====
// Response line parser for a cellular modem's MQTT result lines.
// The line_i channel takes one character per request, with line_last set on
// the final character of a line. The result_o channel gives topic bytes,
// payload bytes and, for the final character, one line result with the event
// code, the two decimal fields and the kept topic and payload lengths.
// A character first lands in an input register; its parse step then runs and
// any result is loaded into the output register, and result_o presents it.
// One character is taken every cycle while the output register is free or being
// read, set by the single parse step from input register to output register;
// characters that give no result still pass through that step.
// When the receiver stalls, the output register holds its request and the
// input side keeps accepting until the input register is also full; ready
// then drops. Reset clears both registers and the line state; any
// partially received line is dropped. After each line result the line state
// returns to its reset value, ready for the next line.
`default_nettype none

module modem_mqtt_response_line_parser #(
  parameter int unsigned TEXT_BYTES = mmrlp_pkg::TEXT_BYTES_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  mmrlp_in_if.sink     line_i,
  mmrlp_out_if.source  result_o
);
  import mmrlp_pkg::*;

  localparam int unsigned CW = $clog2(TEXT_BYTES);

  localparam logic [2:0] PUB_WAIT_TOPIC   = 3'd0;
  localparam logic [2:0] PUB_IN_TOPIC     = 3'd1;
  localparam logic [2:0] PUB_AFTER_TOPIC  = 3'd2;
  localparam logic [2:0] PUB_WAIT_PAYLOAD = 3'd3;
  localparam logic [2:0] PUB_IN_PAYLOAD   = 3'd4;
  localparam logic [2:0] PUB_DONE         = 3'd5;

  localparam pfx_st_t PFX_RESET = '{pos: 4'd0, cand: 6'h3F, code: EV_NONE};
  localparam num_st_t NUM_RESET = '{phase: NUM_SKIP, neg: 1'b0, acc: 32'd0};

  // Input register.
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Line state.
  pfx_st_t    pfx_q, pfx_d, pfx_n;
  num_st_t    num1_q, num1_d, num1_n;
  num_st_t    num2_q, num2_d, num2_n;
  logic       armed_q, armed_d, armed_n;
  logic [2:0] pub_q, pub_d, pub_n;
  logic [CW-1:0] topic_q, topic_d, topic_n;
  logic [CW-1:0] payload_q, payload_d, payload_n;
  logic       ended_q, ended_d, ended_n;

  // Output register.
  logic               out_v_q, out_v_d;
  logic [1:0]         kind_q, kind_d;
  logic [7:0]         text_q, text_d;
  logic [2:0]         code_q, code_d;
  logic signed [31:0] first_q, first_d;
  logic signed [31:0] second_q, second_d;
  logic [7:0]         tlen_q, tlen_d;
  logic [7:0]         plen_q, plen_d;

  logic out_can;
  logic adv;
  logic cons;
  logic matched;
  logic trig;
  logic in_pub;
  logic topic_hit;
  logic payload_hit;
  logic [CW:0] text_sum;
  logic [2:0]  final_code;
  logic [CW+7:0] topic_wide;
  logic [CW+7:0] payload_wide;

  assign out_can      = !out_v_q || result_o.ready;
  assign adv          = in_v_q && out_can;
  assign line_i.ready = !in_v_q || adv;

  assign cons    = !ended_q && (in_byte_q != CH_NUL);
  assign matched = (pfx_q.code != EV_NONE);
  assign in_pub  = cons && matched && (pfx_q.code == EV_PUBLISH);
  assign trig    = (pfx_q.code == EV_PUBLISH) ?
                   ((pub_q == PUB_AFTER_TOPIC) && (in_byte_q == CH_COMMA)) :
                   (in_byte_q == CH_COMMA);

  mmrlp_prefix_match u_prefix (
    .st_i   (pfx_q),
    .char_i (in_byte_q),
    .en_i   (cons),
    .st_o   (pfx_n)
  );

  mmrlp_num_field u_first (
    .st_i   (num1_q),
    .char_i (in_byte_q),
    .en_i   (cons && matched),
    .st_o   (num1_n)
  );

  mmrlp_num_field u_second (
    .st_i   (num2_q),
    .char_i (in_byte_q),
    .en_i   (cons && matched && armed_q),
    .st_o   (num2_n)
  );

  assign armed_n  = armed_q || (cons && matched && trig);
  assign ended_n  = ended_q || (in_byte_q == CH_NUL);
  assign text_sum = {1'b0, topic_q} + {1'b0, payload_q};

  always_comb begin
    pub_n       = pub_q;
    topic_n     = topic_q;
    payload_n   = payload_q;
    topic_hit   = 1'b0;
    payload_hit = 1'b0;
    if (in_pub) begin
      case (pub_q)
        PUB_WAIT_TOPIC: begin
          if (in_byte_q == CH_QUOTE) begin
            pub_n = PUB_IN_TOPIC;
          end
        end
        PUB_IN_TOPIC: begin
          if (in_byte_q == CH_QUOTE) begin
            pub_n = PUB_AFTER_TOPIC;
          end else if (topic_q < CW'(TEXT_BYTES - 1)) begin
            topic_n   = topic_q + 1'b1;
            topic_hit = 1'b1;
          end
        end
        PUB_AFTER_TOPIC: begin
          if (in_byte_q == CH_COMMA) begin
            pub_n = PUB_WAIT_PAYLOAD;
          end
        end
        PUB_WAIT_PAYLOAD: begin
          if (in_byte_q == CH_QUOTE) begin
            pub_n = PUB_IN_PAYLOAD;
          end
        end
        PUB_IN_PAYLOAD: begin
          if (in_byte_q == CH_QUOTE) begin
            pub_n = PUB_DONE;
          end else if (text_sum < (CW + 1)'(TEXT_BYTES - 2)) begin
            payload_n   = payload_q + 1'b1;
            payload_hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Line state after this character; a final character returns it to reset.
  always_comb begin
    if (in_last_q) begin
      pfx_d     = PFX_RESET;
      num1_d    = NUM_RESET;
      num2_d    = NUM_RESET;
      armed_d   = 1'b0;
      pub_d     = PUB_WAIT_TOPIC;
      topic_d   = '0;
      payload_d = '0;
      ended_d   = 1'b0;
    end else begin
      pfx_d     = pfx_n;
      num1_d    = num1_n;
      num2_d    = num2_n;
      armed_d   = armed_n;
      pub_d     = pub_n;
      topic_d   = topic_n;
      payload_d = payload_n;
      ended_d   = ended_n;
    end
  end

  assign final_code   = ((pfx_n.code == EV_PUBLISH) && (pub_n != PUB_DONE)) ?
                        EV_NONE : pfx_n.code;
  assign topic_wide   = {8'd0, topic_n};
  assign payload_wide = {8'd0, payload_n};

  always_comb begin
    out_v_d  = out_v_q;
    kind_d   = kind_q;
    text_d   = text_q;
    code_d   = code_q;
    first_d  = first_q;
    second_d = second_q;
    tlen_d   = tlen_q;
    plen_d   = plen_q;
    if (out_can) begin
      out_v_d  = adv && (in_last_q || topic_hit || payload_hit);
      kind_d   = KIND_TOPIC;
      text_d   = 8'd0;
      code_d   = EV_NONE;
      first_d  = 32'sd0;
      second_d = 32'sd0;
      tlen_d   = 8'd0;
      plen_d   = 8'd0;
      if (in_last_q) begin
        kind_d = KIND_RESULT;
        code_d = final_code;
        if (final_code != EV_NONE) begin
          if (num1_n.neg) begin
            first_d = 32'd0 - num1_n.acc;
          end else begin
            first_d = num1_n.acc[31] ? 32'h7FFFFFFF : num1_n.acc;
          end
          if ((final_code == EV_CONNACK) || (final_code == EV_PUBLISH) ||
              (final_code == EV_PUBACK) || (final_code == EV_SUBACK)) begin
            if (num2_n.neg) begin
              second_d = 32'd0 - num2_n.acc;
            end else begin
              second_d = num2_n.acc[31] ? 32'h7FFFFFFF : num2_n.acc;
            end
          end
          if (final_code == EV_PUBLISH) begin
            tlen_d = topic_wide[7:0];
            plen_d = payload_wide[7:0];
          end
        end
      end else if (topic_hit) begin
        kind_d = KIND_TOPIC;
        text_d = in_byte_q;
      end else if (payload_hit) begin
        kind_d = KIND_PAYLOAD;
        text_d = in_byte_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      pfx_q     <= PFX_RESET;
      num1_q    <= NUM_RESET;
      num2_q    <= NUM_RESET;
      armed_q   <= 1'b0;
      pub_q     <= PUB_WAIT_TOPIC;
      topic_q   <= '0;
      payload_q <= '0;
      ended_q   <= 1'b0;
    end else begin
      in_v_q  <= line_i.ready ? line_i.valid : in_v_q;
      out_v_q <= out_v_d;
      if (adv) begin
        pfx_q     <= pfx_d;
        num1_q    <= num1_d;
        num2_q    <= num2_d;
        armed_q   <= armed_d;
        pub_q     <= pub_d;
        topic_q   <= topic_d;
        payload_q <= payload_d;
        ended_q   <= ended_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_i.ready && line_i.valid) begin
      in_byte_q <= line_i.line_byte;
      in_last_q <= line_i.line_last;
    end
    kind_q   <= kind_d;
    text_q   <= text_d;
    code_q   <= code_d;
    first_q  <= first_d;
    second_q <= second_d;
    tlen_q   <= tlen_d;
    plen_q   <= plen_d;
  end

  assign result_o.valid          = out_v_q;
  assign result_o.item_kind      = kind_q;
  assign result_o.text_byte      = text_q;
  assign result_o.event_code     = code_q;
  assign result_o.first_value    = first_q;
  assign result_o.second_value   = second_q;
  assign result_o.topic_length   = tlen_q;
  assign result_o.payload_length = plen_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mmrlp_prefix_match.sv =====
`default_nettype none

module mmrlp_prefix_match (
  input  mmrlp_pkg::pfx_st_t st_i,
  input  logic [7:0]         char_i,
  input  logic               en_i,
  output mmrlp_pkg::pfx_st_t st_o
);
  import mmrlp_pkg::*;

  always_comb begin
    st_o = st_i;
    if (en_i && (st_i.code == EV_NONE) && (st_i.cand != 6'd0) && (st_i.pos < 4'd15)) begin
      for (int i = 0; i < int'(PFX_COUNT); i++) begin
        if (st_i.cand[i]) begin
          if ((st_i.pos >= pfx_len(3'(i))) || (char_i != pfx_char(3'(i), st_i.pos))) begin
            st_o.cand[i] = 1'b0;
          end else if (st_i.pos == (pfx_len(3'(i)) - 4'd1)) begin
            st_o.code = 3'(i + 1);
          end
        end
      end
      st_o.pos = st_i.pos + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mmrlp_num_field.sv =====
`default_nettype none

module mmrlp_num_field (
  input  mmrlp_pkg::num_st_t st_i,
  input  logic [7:0]         char_i,
  input  logic               en_i,
  output mmrlp_pkg::num_st_t st_o
);
  import mmrlp_pkg::*;

  logic        is_ws;
  logic        is_dig;
  logic [3:0]  dig_val;
  logic [7:0]  dig_diff;
  logic [35:0] scaled;

  assign is_ws    = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
  assign is_dig   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign dig_diff = char_i - CH_ZERO;
  assign dig_val  = dig_diff[3:0];
  assign scaled   = {1'b0, st_i.acc, 3'b000} + {3'b000, st_i.acc, 1'b0} + {32'd0, dig_val};

  always_comb begin
    st_o = st_i;
    if (en_i) begin
      case (st_i.phase)
        NUM_SKIP: begin
          if (!is_ws) begin
            if ((char_i == CH_PLUS) || (char_i == CH_MINUS)) begin
              st_o.neg   = (char_i == CH_MINUS);
              st_o.phase = NUM_DIGITS;
            end else if (is_dig) begin
              st_o.acc   = {28'd0, dig_val};
              st_o.phase = NUM_DIGITS;
            end else begin
              st_o.phase = NUM_DONE;
            end
          end
        end
        NUM_DIGITS: begin
          if (is_dig) begin
            if (scaled > 36'h080000000) begin
              st_o.acc = 32'h80000000;
            end else begin
              st_o.acc = scaled[31:0];
            end
          end else begin
            st_o.phase = NUM_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/modem_mqtt_response_line_parser_tb.sv =====
`timescale 1ns / 1ps

module modem_mqtt_response_line_parser_tb;
  import mmrlp_pkg::*;

  localparam int unsigned TEXT_CAP = TEXT_BYTES_DEF;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 560;
  localparam int unsigned MAX_REPORTS = 50;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PUB_OPEN_TOPIC,
    PUB_IN_TOPIC,
    PUB_AFTER_TOPIC,
    PUB_OPEN_PAYLOAD,
    PUB_IN_PAYLOAD,
    PUB_CLOSED
  } pub_step_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text;
    logic [2:0]  code;
    logic [31:0] first;
    logic [31:0] second;
    logic [7:0]  topic_size;
    logic [7:0]  payload_size;
  } parse_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mmrlp_in_if  line_if ();
  mmrlp_out_if result_if ();

  modem_mqtt_response_line_parser #(
    .TEXT_BYTES(TEXT_CAP)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .line_i  (line_if),
    .result_o(result_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  line_char_t  chars_to_send[$];
  parse_item_t parse_items_due[$];
  logic [7:0]  line_buf[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned stim_phase;
  int unsigned phase_bytes;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        timed_out = 1'b0;

  // Line state of the parser as predicted by the testbench.
  int unsigned pfx_pos;
  logic [5:0]  pfx_alive;
  logic [2:0]  line_code;
  pub_step_e   pub_step;
  num_st_t     id_field;
  num_st_t     aux_field;
  logic        aux_armed;
  int unsigned topic_kept;
  int unsigned payload_kept;
  logic        line_dead;

  function automatic void clear_line_state();
    pfx_pos = 0;
    pfx_alive = '1;
    line_code = EV_NONE;
    pub_step = PUB_OPEN_TOPIC;
    id_field = '{phase: NUM_SKIP, neg: 1'b0, acc: '0};
    aux_field = '{phase: NUM_SKIP, neg: 1'b0, acc: '0};
    aux_armed = 1'b0;
    topic_kept = 0;
    payload_kept = 0;
    line_dead = 1'b0;
  endfunction

  function automatic string prefix_tail(input int idx);
    case (idx)
      0: return "CONNECT:";
      1: return "CONNACK:";
      2: return "PUBLISH:";
      3: return "PUBACK:";
      4: return "SUBACK:";
      default: return "DISC:";
    endcase
  endfunction

  function automatic logic [2:0] prefix_code(input int idx);
    case (idx)
      0: return EV_CONNECT;
      1: return EV_CONNACK;
      2: return EV_PUBLISH;
      3: return EV_PUBACK;
      4: return EV_SUBACK;
      default: return EV_DISC;
    endcase
  endfunction

  function automatic int unsigned prefix_len(input int idx);
    return 6 + prefix_tail(idx).len();
  endfunction

  function automatic logic [7:0] prefix_char(input int idx, input int unsigned pos);
    string tail;
    tail = prefix_tail(idx);
    if (pos < 6) begin
      return PFX_HEAD[8 * (5 - pos) +: 8];
    end
    return tail[pos - 6];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic num_st_t num_feed(input num_st_t f, input logic [7:0] c);
    logic        digit;
    logic [63:0] wide;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    case (f.phase)
      NUM_SKIP: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            f.neg = (c == CH_MINUS);
            f.phase = NUM_DIGITS;
          end else if (digit) begin
            f.acc = 32'(c - CH_ZERO);
            f.phase = NUM_DIGITS;
          end else begin
            f.phase = NUM_DONE;
          end
        end
      end
      NUM_DIGITS: begin
        if (digit) begin
          wide = 64'(f.acc) * 10 + 64'(c - CH_ZERO);
          if (wide > 64'h8000_0000) wide = 64'h8000_0000;
          f.acc = wide[31:0];
        end else begin
          f.phase = NUM_DONE;
        end
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] field_value(input num_st_t f);
    if (f.neg) return -f.acc;
    return (f.acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : f.acc;
  endfunction

  function automatic void step_char(input logic [7:0] c, output logic emit,
                                    output logic [1:0] kind);
    logic        fire;
    int unsigned room;
    int          i;
    emit = 1'b0;
    kind = KIND_TOPIC;
    if (line_code == EV_NONE) begin
      if (pfx_alive != '0 && pfx_pos <= PFX_MAX_LEN) begin
        for (i = 0; i < PFX_COUNT; i++) begin
          if (pfx_alive[i]) begin
            if (pfx_pos >= prefix_len(i) || c != prefix_char(i, pfx_pos)) begin
              pfx_alive[i] = 1'b0;
            end else if (pfx_pos == prefix_len(i) - 1) begin
              line_code = prefix_code(i);
            end
          end
        end
        pfx_pos++;
      end
    end else begin
      id_field = num_feed(id_field, c);
      if (line_code == EV_PUBLISH) begin
        fire = (pub_step == PUB_AFTER_TOPIC) && (c == CH_COMMA);
      end else begin
        fire = (c == CH_COMMA);
      end
      if (!aux_armed) begin
        aux_armed = fire;
      end else begin
        aux_field = num_feed(aux_field, c);
      end
      if (line_code == EV_PUBLISH) begin
        case (pub_step)
          PUB_OPEN_TOPIC: if (c == CH_QUOTE) pub_step = PUB_IN_TOPIC;
          PUB_IN_TOPIC: begin
            if (c == CH_QUOTE) begin
              pub_step = PUB_AFTER_TOPIC;
            end else if (topic_kept < TEXT_CAP - 1) begin
              topic_kept++;
              emit = 1'b1;
              kind = KIND_TOPIC;
            end
          end
          PUB_AFTER_TOPIC: if (c == CH_COMMA) pub_step = PUB_OPEN_PAYLOAD;
          PUB_OPEN_PAYLOAD: if (c == CH_QUOTE) pub_step = PUB_IN_PAYLOAD;
          PUB_IN_PAYLOAD: begin
            if (c == CH_QUOTE) begin
              pub_step = PUB_CLOSED;
            end else begin
              room = (topic_kept + 2 < TEXT_CAP) ? TEXT_CAP - 2 - topic_kept : 0;
              if (payload_kept < room) begin
                payload_kept++;
                emit = 1'b1;
                kind = KIND_PAYLOAD;
              end
            end
          end
          default: ;
        endcase
      end
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic last);
    logic        emit;
    logic [1:0]  kind;
    parse_item_t item;
    emit = 1'b0;
    kind = KIND_TOPIC;
    if (!line_dead) begin
      if (c == CH_NUL) begin
        line_dead = 1'b1;
      end else begin
        step_char(c, emit, kind);
      end
    end
    item = '0;
    if (last) begin
      item.kind = KIND_RESULT;
      item.code = line_code;
      if (line_code == EV_PUBLISH && pub_step != PUB_CLOSED) item.code = EV_NONE;
      if (item.code != EV_NONE) begin
        item.first = field_value(id_field);
        if (item.code >= EV_CONNACK && item.code <= EV_SUBACK) begin
          item.second = field_value(aux_field);
        end
        if (item.code == EV_PUBLISH) begin
          item.topic_size = topic_kept[7:0];
          item.payload_size = payload_kept[7:0];
        end
      end
      clear_line_state();
      parse_items_due.push_back(item);
    end else if (emit) begin
      item.kind = kind;
      item.text = c;
      parse_items_due.push_back(item);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] due);
    if (seen !== due) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, seen, due));
    end
  endtask

  task automatic put_char(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic put_prefix(input int idx);
    int unsigned i;
    for (i = 0; i < prefix_len(idx); i++) put_char(prefix_char(idx, i));
  endtask

  task automatic put_spaces();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        put_char(($urandom_range(0, 1) == 0) ? CH_SPACE :
                 8'(CH_TAB + $urandom_range(0, 4)));
      end
    end
  endtask

  task automatic put_number();
    int r;
    int n;
    put_spaces();
    r = $urandom_range(0, 3);
    if (r == 0) put_char(CH_MINUS);
    else if (r == 1) put_char(CH_PLUS);
    r = $urandom_range(0, 11);
    if (r >= 1 && r <= 9) begin
      n = (r <= 7) ? $urandom_range(1, 3) : $urandom_range(9, 12);
      repeat (n) put_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (r > 9) begin
      case ($urandom_range(0, 4))
        0: put_str("2147483647");
        1: put_str("2147483648");
        2: put_str("2147483649");
        3: put_str("4294967296");
        default: put_str("99999999999");
      endcase
    end
  endtask

  task automatic put_text(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) :
                                        8'($urandom_range(32, 126));
      if (c == CH_QUOTE) c = CH_PLUS;
      put_char(c);
    end
  endtask

  task automatic put_publish_body(input int topic_n, input int payload_n);
    put_number();
    put_char(CH_COMMA);
    put_spaces();
    put_char(CH_QUOTE);
    put_text(topic_n);
    put_char(CH_QUOTE);
    put_char(CH_COMMA);
    put_number();
    put_char(CH_COMMA);
    put_char(CH_QUOTE);
    put_text(payload_n);
    put_char(CH_QUOTE);
  endtask

  function automatic int text_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r <= 17) return $urandom_range(1, 8);
    return $urandom_range(9, 30);
  endfunction

  task automatic commit_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      chars_to_send.push_back('{ch: line_buf[i], last: (i == line_buf.size() - 1)});
    end
    phase_bytes += line_buf.size();
    line_buf.delete();
  endtask

  task automatic capacity_line();
    put_prefix(2);
    put_publish_body($urandom_range(245, 258), $urandom_range(0, 12));
    put_char(CH_CR);
    put_char(CH_LF);
    commit_line();
  endtask

  task automatic random_line();
    int sel;
    int idx;
    int cut;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 10)) put_char(8'($urandom_range(0, 255)));
    end else begin
      idx = (sel < 40) ? 2 : $urandom_range(0, 5);
      put_prefix(idx);
      if ($urandom_range(0, 19) == 0) begin
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (idx == 2) begin
        put_publish_body(text_len(), text_len());
      end else begin
        put_number();
        if (idx == 1 || idx == 3 || idx == 4 || $urandom_range(0, 3) == 0) begin
          put_char(CH_COMMA);
          put_number();
        end
      end
      if ($urandom_range(0, 3) == 0) put_text($urandom_range(1, 4));
      put_char(CH_CR);
      put_char(CH_LF);
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
          0: while (line_buf.size() > cut + 1) void'(line_buf.pop_back());
          1: line_buf.delete(cut);
          default: line_buf[cut] = CH_NUL;
        endcase
      end
    end
    commit_line();
  endtask

  task automatic fill_phase();
    phase_bytes = 0;
    capacity_line();
    while (phase_bytes < PHASE_BYTES) random_line();
  endtask

  task automatic wait_sent();
    while ((chars_to_send.size() != 0 || line_if.valid) && !timed_out) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_line
    line_char_t nxt;
    if (rst_ni) begin
      if (line_if.valid && line_if.ready) parse_char(line_if.line_byte, line_if.line_last);
      if (!line_if.valid || line_if.ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = chars_to_send.pop_front();
          line_if.valid <= 1'b1;
          line_if.line_byte <= nxt.ch;
          line_if.line_last <= nxt.last;
        end else begin
          line_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (stim_phase == 3 && !hold_done) begin
        hold_left <= HOLD_OFF_CYCLES;
        hold_done <= 1'b1;
        result_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    parse_item_t seen;
    parse_item_t due;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        seen.kind = result_if.item_kind;
        seen.text = result_if.text_byte;
        seen.code = result_if.event_code;
        seen.first = result_if.first_value;
        seen.second = result_if.second_value;
        seen.topic_size = result_if.topic_length;
        seen.payload_size = result_if.payload_length;
        if (parse_items_due.size() == 0) begin
          report_mismatch($sformatf("unexpected item of kind %0d", seen.kind));
        end else begin
          due = parse_items_due.pop_front();
          check_field("item_kind", seen.kind, due.kind);
          check_field("text_byte", seen.text, due.text);
          check_field("event_code", seen.code, due.code);
          check_field("first_value", seen.first, due.first);
          check_field("second_value", seen.second, due.second);
          check_field("topic_length", seen.topic_size, due.topic_size);
          check_field("payload_length", seen.payload_size, due.payload_size);
        end
      end
      if ((line_if.valid && line_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    line_if.valid = 1'b0;
    line_if.line_byte = CH_NUL;
    line_if.line_last = 1'b0;
    result_if.ready = 1'b0;
    clear_line_state();
    src_idle_pct = 37;
    sink_idle_pct = 63;
    stim_phase = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A saturating negative field, a lone high byte, and a line cut short by a zero byte.
    put_prefix(5);
    put_char(CH_SPACE);
    put_char(CH_MINUS);
    put_str("2147483649");
    put_char(CH_LF);
    commit_line();
    put_char(8'hFF);
    commit_line();
    put_char(CH_NUL);
    put_char(CH_PLUS);
    commit_line();

    fill_phase();
    wait_sent();
    src_idle_pct = 63;
    sink_idle_pct = 37;
    stim_phase = 2;
    fill_phase();
    wait_sent();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    stim_phase = 3;
    fill_phase();
    wait_sent();
    while (parse_items_due.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (parse_items_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected items never arrived", parse_items_due.size()));
    end
    if (mismatch_count == 0 && !timed_out) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mmrlp_pkg.sv
hw/rtl/mmrlp_if.sv
hw/rtl/mmrlp_prefix_match.sv
hw/rtl/mmrlp_num_field.sv
hw/rtl/modem_mqtt_response_line_parser.sv
tb/modem_mqtt_response_line_parser_tb.sv
